// ----- design/complex_arithmetic_unit_defines.svh -----
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property forms, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define CAU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, antecedent may be a sequence
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// widths, opcodes, word types and pipeline stage types of the complex alu
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PW         = 2 * DATA_WIDTH;       // product width
   localparam int SW         = PW + 1;               // sum / magnitude width
   localparam int RW         = SW;                   // divider remainder width
   localparam int NW         = SW + FRAC_BITS;       // scaled numerator width
   localparam int N_STEP     = DATA_WIDTH;           // quotient / root bits

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_CONJ  = 3'd4;
   localparam logic [2:0] OP_SCALE = 3'd5;
   localparam logic [2:0] OP_MAG   = 3'd6;

   localparam logic [SW-1:0] POS_LIM = (SW'(1) << (DATA_WIDTH - 1)) - SW'(1);
   localparam logic [SW-1:0] NEG_LIM = SW'(1) << (DATA_WIDTH - 1);
   localparam logic signed [DATA_WIDTH-1:0] RES_MAX = DATA_WIDTH'(POS_LIM);
   localparam logic signed [DATA_WIDTH-1:0] RES_MIN = DATA_WIDTH'(NEG_LIM);

   typedef struct packed {
      logic [2:0]                   opcode;
      logic signed [DATA_WIDTH-1:0] a_re;
      logic signed [DATA_WIDTH-1:0] a_im;
      logic signed [DATA_WIDTH-1:0] b_re;
      logic signed [DATA_WIDTH-1:0] b_im;
      logic signed [DATA_WIDTH-1:0] scale;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_re;
      logic signed [DATA_WIDTH-1:0] result_im;
      logic                         overflow;
      logic                         divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic [2:0]                   op;
      logic signed [PW-1:0]         p0;
      logic signed [PW-1:0]         p1;
      logic signed [PW-1:0]         p2;
      logic signed [PW-1:0]         p3;
      logic signed [PW-1:0]         p4;
      logic signed [PW-1:0]         p5;
      logic signed [DATA_WIDTH:0]   lin_re;
      logic signed [DATA_WIDTH:0]   lin_im;
   } mul_type;

   typedef struct packed {
      logic                 valid;
      logic [2:0]           op;
      logic                 dz;
      logic signed [SW-1:0] re_val;
      logic signed [SW-1:0] im_val;
      logic [PW-1:0]        sq;
   } cmb_type;

   typedef struct packed {
      logic          valid;
      logic [2:0]    op;
      logic          dz;
      logic          neg_re;
      logic          neg_im;
      logic [SW-1:0] mag_re;
      logic [SW-1:0] mag_im;
      logic [PW-1:0] sq;
   } sm_type;

   // iteration stage word; magnitude reuses den as radicand shift register,
   // rem_re as root remainder and nb_re as partial root
   typedef struct packed {
      logic                  valid;
      logic [2:0]            op;
      logic                  dz;
      logic                  neg_re;
      logic                  neg_im;
      logic                  big_re;
      logic                  big_im;
      logic [RW-1:0]         rem_re;
      logic [RW-1:0]         rem_im;
      logic [DATA_WIDTH-1:0] nb_re;
      logic [DATA_WIDTH-1:0] nb_im;
      logic [PW-1:0]         den;
   } it_type;

   typedef struct packed {
      logic                  valid;
      logic                  neg_re;
      logic                  neg_im;
      logic [DATA_WIDTH:0]   m_re;
      logic [DATA_WIDTH:0]   m_im;
      logic                  ovf;
      logic                  dz;
   } fin_type;

   function automatic logic signed [DATA_WIDTH:0] ext_d1(
      input logic signed [DATA_WIDTH-1:0] v);
      return {v[DATA_WIDTH-1], v};
   endfunction

   function automatic logic signed [PW-1:0] ext_d2(
      input logic signed [DATA_WIDTH-1:0] v);
      return {{DATA_WIDTH{v[DATA_WIDTH-1]}}, v};
   endfunction

   function automatic logic signed [SW-1:0] ext_p(input logic signed [PW-1:0] v);
      return {v[PW-1], v};
   endfunction

   function automatic logic signed [SW-1:0] ext_l(
      input logic signed [DATA_WIDTH:0] v);
      return {{(SW - DATA_WIDTH - 1){v[DATA_WIDTH]}}, v};
   endfunction

endpackage

// ----- design/cau_mult.sv -----
// ----------------------------------------------------------------------------
// cau_mult
// operand products and linear terms, then the real and imaginary sums
// ----------------------------------------------------------------------------
module cau_mult import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    req_valid,
   input  req_type req,
   output cmb_type cmb_out
);

   mul_type mul_in, mul_ff;
   cmb_type cmb_in, cmb_ff;
   logic signed [DATA_WIDTH-1:0] p0_b, p1_b, sq_x, sq_y;
   logic is_scale, is_div;

   always_comb begin
      is_scale = (req.opcode == OP_SCALE);
      is_div   = (req.opcode == OP_DIV);
      p0_b = is_scale ? req.scale : req.b_re;
      p1_b = is_scale ? req.scale : req.b_im;
      sq_x = is_div ? req.b_re : req.a_re;
      sq_y = is_div ? req.b_im : req.a_im;

      mul_in.valid = req_valid;
      mul_in.op    = req.opcode;
      mul_in.p0    = ext_d2(req.a_re) * ext_d2(p0_b);
      mul_in.p1    = ext_d2(req.a_im) * ext_d2(p1_b);
      mul_in.p2    = ext_d2(req.a_re) * ext_d2(req.b_im);
      mul_in.p3    = ext_d2(req.a_im) * ext_d2(req.b_re);
      mul_in.p4    = ext_d2(sq_x) * ext_d2(sq_x);
      mul_in.p5    = ext_d2(sq_y) * ext_d2(sq_y);
      case (req.opcode)
         OP_ADD: begin
            mul_in.lin_re = ext_d1(req.a_re) + ext_d1(req.b_re);
            mul_in.lin_im = ext_d1(req.a_im) + ext_d1(req.b_im);
         end
         OP_SUB: begin
            mul_in.lin_re = ext_d1(req.a_re) - ext_d1(req.b_re);
            mul_in.lin_im = ext_d1(req.a_im) - ext_d1(req.b_im);
         end
         OP_CONJ: begin
            mul_in.lin_re = ext_d1(req.a_re);
            mul_in.lin_im = -ext_d1(req.a_im);
         end
         default: begin
            mul_in.lin_re = '0;
            mul_in.lin_im = '0;
         end
      endcase
   end

   always_comb begin
      cmb_in.valid = mul_ff.valid;
      cmb_in.op    = mul_ff.op;
      cmb_in.sq    = PW'($unsigned(mul_ff.p4)) + PW'($unsigned(mul_ff.p5));
      cmb_in.dz    = (mul_ff.op == OP_DIV) && (cmb_in.sq == '0);
      case (mul_ff.op)
         OP_ADD, OP_SUB, OP_CONJ: begin
            cmb_in.re_val = ext_l(mul_ff.lin_re);
            cmb_in.im_val = ext_l(mul_ff.lin_im);
         end
         OP_MUL: begin
            cmb_in.re_val = ext_p(mul_ff.p0) - ext_p(mul_ff.p1);
            cmb_in.im_val = ext_p(mul_ff.p2) + ext_p(mul_ff.p3);
         end
         OP_DIV: begin
            cmb_in.re_val = ext_p(mul_ff.p0) + ext_p(mul_ff.p1);
            cmb_in.im_val = ext_p(mul_ff.p3) - ext_p(mul_ff.p2);
         end
         OP_SCALE: begin
            cmb_in.re_val = ext_p(mul_ff.p0);
            cmb_in.im_val = ext_p(mul_ff.p1);
         end
         default: begin
            cmb_in.re_val = '0;
            cmb_in.im_val = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
         cmb_ff.valid <= 1'b0;
      end else if (en) begin
         mul_ff <= mul_in;
         cmb_ff <= cmb_in;
      end
   end

   assign cmb_out = cmb_ff;

endmodule

// ----- design/cau_sm.sv -----
// ----------------------------------------------------------------------------
// cau_sm
// sign-magnitude conversion with truncating shift, then divider setup
// ----------------------------------------------------------------------------
module cau_sm import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  cmb_type cmb,
   output it_type  it_out
);

   sm_type sm_in, sm_ff;
   it_type it_in, it_ff;
   logic [SW-1:0] abs_re, abs_im;
   logic [NW-1:0] n_re, n_im;
   logic [RW-1:0] rem0_re, rem0_im, den_x;
   logic          shift_op;

   always_comb begin
      abs_re   = cmb.re_val[SW-1] ? SW'(-cmb.re_val) : SW'(cmb.re_val);
      abs_im   = cmb.im_val[SW-1] ? SW'(-cmb.im_val) : SW'(cmb.im_val);
      shift_op = (cmb.op == OP_MUL) || (cmb.op == OP_SCALE);
      sm_in.valid  = cmb.valid;
      sm_in.op     = cmb.op;
      sm_in.dz     = cmb.dz;
      sm_in.neg_re = cmb.re_val[SW-1];
      sm_in.neg_im = cmb.im_val[SW-1];
      sm_in.mag_re = shift_op ? (abs_re >> FRAC_BITS) : abs_re;
      sm_in.mag_im = shift_op ? (abs_im >> FRAC_BITS) : abs_im;
      sm_in.sq     = cmb.sq;
   end

   // numerator scaled by the fraction bits; its top part seeds the remainder
   always_comb begin
      n_re    = NW'(sm_ff.mag_re) << FRAC_BITS;
      n_im    = NW'(sm_ff.mag_im) << FRAC_BITS;
      rem0_re = RW'(n_re >> DATA_WIDTH);
      rem0_im = RW'(n_im >> DATA_WIDTH);
      den_x   = RW'(sm_ff.sq);

      it_in.valid  = sm_ff.valid;
      it_in.op     = sm_ff.op;
      it_in.dz     = sm_ff.dz;
      it_in.neg_re = sm_ff.neg_re;
      it_in.neg_im = sm_ff.neg_im;
      it_in.den    = sm_ff.sq;
      case (sm_ff.op)
         OP_DIV: begin
            it_in.rem_re = rem0_re;
            it_in.rem_im = rem0_im;
            it_in.nb_re  = DATA_WIDTH'(n_re);
            it_in.nb_im  = DATA_WIDTH'(n_im);
            it_in.big_re = (rem0_re >= den_x);
            it_in.big_im = (rem0_im >= den_x);
         end
         OP_MAG: begin
            it_in.rem_re = '0;
            it_in.rem_im = '0;
            it_in.nb_re  = '0;
            it_in.nb_im  = '0;
            it_in.big_re = 1'b0;
            it_in.big_im = 1'b0;
         end
         default: begin
            it_in.rem_re = sm_ff.mag_re;
            it_in.rem_im = sm_ff.mag_im;
            it_in.nb_re  = '0;
            it_in.nb_im  = '0;
            it_in.big_re = 1'b0;
            it_in.big_im = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff.valid <= 1'b0;
         it_ff.valid <= 1'b0;
      end else if (en) begin
         sm_ff <= sm_in;
         it_ff <= it_in;
      end
   end

   assign it_out = it_ff;

endmodule

// ----- design/cau_step.sv -----
// ----------------------------------------------------------------------------
// cau_step
// one registered digit step: a quotient bit per lane, or one root bit
// ----------------------------------------------------------------------------
module cau_step import cau_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  it_type it_d,
   output it_type it_q
);

   it_type        it_in, it_ff;
   logic [RW-1:0] den_x, t_re, t_im, t_sq, trial;
   logic          ge_re, ge_im, ge_sq;

   always_comb begin
      den_x = RW'(it_d.den);
      t_re  = {it_d.rem_re[RW-2:0], it_d.nb_re[DATA_WIDTH-1]};
      t_im  = {it_d.rem_im[RW-2:0], it_d.nb_im[DATA_WIDTH-1]};
      ge_re = (t_re >= den_x);
      ge_im = (t_im >= den_x);
      // root step: bring in two radicand bits, try 4*root+1
      t_sq  = {it_d.rem_re[RW-3:0], it_d.den[PW-1:PW-2]};
      trial = RW'({it_d.nb_re, 2'b01});
      ge_sq = (t_sq >= trial);

      it_in = it_d;
      case (it_d.op)
         OP_DIV: begin
            it_in.rem_re = ge_re ? (t_re - den_x) : t_re;
            it_in.rem_im = ge_im ? (t_im - den_x) : t_im;
            it_in.nb_re  = {it_d.nb_re[DATA_WIDTH-2:0], ge_re};
            it_in.nb_im  = {it_d.nb_im[DATA_WIDTH-2:0], ge_im};
         end
         OP_MAG: begin
            it_in.rem_re = ge_sq ? (t_sq - trial) : t_sq;
            it_in.nb_re  = {it_d.nb_re[DATA_WIDTH-2:0], ge_sq};
            it_in.den    = it_d.den << 2;
         end
         default: begin
            it_in = it_d;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         it_ff.valid <= 1'b0;
      end else if (en) begin
         it_ff <= it_in;
      end
   end

   assign it_q = it_ff;

endmodule

// ----- design/cau_out.sv -----
// ----------------------------------------------------------------------------
// cau_out
// result selection and saturation, then the signed output register
// ----------------------------------------------------------------------------
module cau_out import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  it_type  it_d,
   output logic    rsp_valid,
   output rsp_type rsp
);

   fin_type       fin_in, fin_ff;
   rsp_type       rsp_in, rsp_ff;
   logic          rsp_valid_ff;
   logic [SW-1:0] m_re, m_im, lim_re, lim_im;
   logic          neg_re, neg_im, big_re, big_im, ovf_re, ovf_im;
   logic [DATA_WIDTH:0] v_re, v_im;

   always_comb begin
      neg_re = it_d.neg_re;
      neg_im = it_d.neg_im;
      big_re = 1'b0;
      big_im = 1'b0;
      case (it_d.op)
         OP_DIV: begin
            m_re   = SW'(it_d.nb_re);
            m_im   = SW'(it_d.nb_im);
            big_re = it_d.big_re;
            big_im = it_d.big_im;
         end
         OP_MAG: begin
            m_re   = SW'(it_d.nb_re);
            m_im   = '0;
            neg_re = 1'b0;
            neg_im = 1'b0;
         end
         default: begin
            m_re = it_d.rem_re;
            m_im = it_d.rem_im;
         end
      endcase
      if (it_d.dz) begin
         m_re   = '0;
         m_im   = '0;
         neg_re = 1'b0;
         neg_im = 1'b0;
         big_re = 1'b0;
         big_im = 1'b0;
      end
      lim_re = neg_re ? NEG_LIM : POS_LIM;
      lim_im = neg_im ? NEG_LIM : POS_LIM;
      ovf_re = big_re || (m_re > lim_re);
      ovf_im = big_im || (m_im > lim_im);

      fin_in.valid  = it_d.valid;
      fin_in.neg_re = neg_re;
      fin_in.neg_im = neg_im;
      fin_in.m_re   = (DATA_WIDTH + 1)'(ovf_re ? lim_re : m_re);
      fin_in.m_im   = (DATA_WIDTH + 1)'(ovf_im ? lim_im : m_im);
      fin_in.ovf    = ovf_re || ovf_im;
      fin_in.dz     = it_d.dz;
   end

   always_comb begin
      v_re = fin_ff.neg_re ? (~fin_ff.m_re + (DATA_WIDTH + 1)'(1)) : fin_ff.m_re;
      v_im = fin_ff.neg_im ? (~fin_ff.m_im + (DATA_WIDTH + 1)'(1)) : fin_ff.m_im;
      rsp_in.result_re      = v_re[DATA_WIDTH-1:0];
      rsp_in.result_im      = v_im[DATA_WIDTH-1:0];
      rsp_in.overflow       = fin_ff.ovf;
      rsp_in.divide_by_zero = fin_ff.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         fin_ff       <= fin_in;
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= fin_ff.valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- design/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex alu on signed q16.16 words: add, sub, mul, div,
// conjugate, real scale and magnitude, with saturation and flags
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word, in order. The pipeline is: operand products,
// real/imaginary sums, sign-magnitude conversion, divider setup, 32 digit
// stages (one quotient bit per lane for divide, one root bit for magnitude,
// plain pass for the other opcodes), saturation, and the output register.
// The 32 digit stages set the depth. A stalled output freezes the whole
// pipeline; req_stall follows rsp_stall only while a result is waiting.
// Opcode 7 gives zero with no flags.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    en;          // whole pipeline advances together
   cmb_type cmb;         // sums after the product stage
   it_type  it_q [0:N_STEP];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // products and sums
   cau_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req       (req_data),
      .cmb_out   (cmb)
   );

   // sign-magnitude form and divider seed
   cau_sm u_sm (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .cmb    (cmb),
      .it_out (it_q[0])
   );

   // digit stages for quotient and root
   for (genvar g = 0; g < N_STEP; g++) begin : g_step
      cau_step u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .it_d  (it_q[g]),
         .it_q  (it_q[g+1])
      );
   end

   // saturation and output word register
   cau_out u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .it_d      (it_q[N_STEP]),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // a zero divisor gives a clean zero with no overflow
   `CAU_ASSERT_IMPLY(a_dz_zero, rsp_valid && rsp_data.divide_by_zero, rsp_data.result_re == '0 && rsp_data.result_im == '0 && !rsp_data.overflow, "divide by zero word not zero")
   // overflow only with a part pinned at a limit
   `CAU_ASSERT_IMPLY(a_ovf_limit, rsp_valid && rsp_data.overflow, rsp_data.result_re == RES_MAX || rsp_data.result_re == RES_MIN || rsp_data.result_im == RES_MAX || rsp_data.result_im == RES_MIN, "overflow without saturated part")
   // an accepted word reaches the sum stage through the product register while the pipeline advances
   `CAU_ASSERT_NEXT(a_front_flow, (req_valid && !req_stall) ##1 !req_stall, cmb.valid, "accepted word lost in front stages")

endmodule
